// File: rtl/eaxes_pkg.sv
// ----------------------------------------------------------------------------
// eaxes_pkg
// Shared types, constants and the micro-op sequence for the Euler angle to
// axes block: register names, post-multiply operations and Q30 helpers.
// ----------------------------------------------------------------------------
package eaxes_pkg;

    // Q30 fixed point: 2^30 is 1.0
    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
    localparam logic signed [63:0] Q30_ONE64 = 64'sd1073741824;

    // odd Taylor coefficients of sin(pi/2 * u), Q30
    localparam logic signed [31:0] C1  = 32'sd1686629713;
    localparam logic signed [31:0] C3  = 32'sd693598668;
    localparam logic signed [31:0] C5  = 32'sd85569306;
    localparam logic signed [31:0] C7  = 32'sd5026995;
    localparam logic signed [31:0] C9  = 32'sd172272;
    localparam logic signed [31:0] C11 = 32'sd3864;

    // input opcodes
    localparam logic [2:0] OPC_SET_PITCH = 3'd0;
    localparam logic [2:0] OPC_SET_YAW   = 3'd1;
    localparam logic [2:0] OPC_SET_ROLL  = 3'd2;
    localparam logic [2:0] OPC_OFS_PITCH = 3'd3;
    localparam logic [2:0] OPC_OFS_YAW   = 3'd4;
    localparam logic [2:0] OPC_OFS_ROLL  = 3'd5;

    // result component slots
    localparam int NCOMP = 9;
    localparam logic [3:0] CI_FX = 4'd0;
    localparam logic [3:0] CI_FY = 4'd1;
    localparam logic [3:0] CI_FZ = 4'd2;
    localparam logic [3:0] CI_RX = 4'd3;
    localparam logic [3:0] CI_RY = 4'd4;
    localparam logic [3:0] CI_RZ = 4'd5;
    localparam logic [3:0] CI_DX = 4'd6;
    localparam logic [3:0] CI_DY = 4'd7;
    localparam logic [3:0] CI_DZ = 4'd8;

    // angle select
    localparam logic [1:0] ANG_PITCH = 2'd0;
    localparam logic [1:0] ANG_YAW   = 2'd1;

    // last micro-op index
    localparam logic [5:0] UOP_LAST = 6'd63;

    // register file entries (sin/cos order: pitch, yaw, roll)
    typedef enum logic [3:0] {
        R_U, R_W, R_R, R_T, R_SP, R_CP, R_SY, R_CY,
        R_SR, R_CR, R_FX, R_FY, R_FZ, R_RX, R_RY, R_RZ
    } t_reg;

    // operation applied to the product
    typedef enum logic [3:0] {
        P_RND, P_KSUB, P_SIN, P_SAT, P_NEGSAT, P_SUBT, P_ADDT, P_HOLD, P_XSUB
    } t_post;

    typedef enum logic [2:0] {
        CF_C9, CF_C7, CF_C5, CF_C3, CF_C1
    } t_coef;

    typedef enum logic {
        U_LDU, U_MUL
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        t_reg       a;
        logic       a_c11;
        t_reg       b;
        logic       b_one;
        t_post      post;
        t_coef      coef;
        t_reg       dst;
        logic       mem_we;
        logic       comp_we;
        logic [3:0] comp_idx;
        logic [1:0] ang_sel;
        logic       ang_cos;
    } t_uop;

    typedef struct packed {
        logic capture;
        logic upd;
        logic ldu;
        logic rd;
        logic mul;
        logic post;
        logic out_load;
        t_uop uop;
    } t_dp_cmd;

    function automatic logic signed [31:0] coef_value(input t_coef c);
        logic signed [31:0] v;
        unique case (c)
            CF_C9:   v = C9;
            CF_C7:   v = C7;
            CF_C5:   v = C5;
            CF_C3:   v = C3;
            default: v = C1;
        endcase
        return v;
    endfunction

    // round half away from zero, drop 30 fraction bits
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] q;
        mag = p[63] ? 64'(-p) : 64'(p);
        q   = (mag + 64'd536870912) >> 30;
        return p[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] sat_q30(input logic signed [63:0] v);
        logic signed [63:0] s;
        if (v > Q30_ONE64) begin
            s = Q30_ONE64;
        end else if (v < -Q30_ONE64) begin
            s = -Q30_ONE64;
        end else begin
            s = v;
        end
        return s[31:0];
    endfunction

    function automatic t_uop set_mul(input t_uop base, input t_reg a, input t_reg b,
                                     input t_post p, input t_reg dst, input logic we);
        t_uop u;
        u        = base;
        u.kind   = U_MUL;
        u.a      = a;
        u.b      = b;
        u.post   = p;
        u.dst    = dst;
        u.mem_we = we;
        return u;
    endfunction

    function automatic t_uop set_comp(input t_uop base, input logic [3:0] ci);
        t_uop u;
        u          = base;
        u.comp_we  = 1'b1;
        u.comp_idx = ci;
        return u;
    endfunction

    // micro-op sequence: six sine evaluations, then the axes
    function automatic t_uop uop_at(input logic [5:0] idx);
        t_uop       u;
        logic [2:0] k;
        t_reg       tr;
        k          = idx[5:3];
        tr         = t_reg'(4'(R_SP) + {1'b0, k});
        u.kind     = U_MUL;
        u.a        = R_U;
        u.a_c11    = 1'b0;
        u.b        = R_U;
        u.b_one    = 1'b0;
        u.post     = P_RND;
        u.coef     = CF_C9;
        u.dst      = R_U;
        u.mem_we   = 1'b0;
        u.comp_we  = 1'b0;
        u.comp_idx = CI_FX;
        u.ang_sel  = k[2:1];
        u.ang_cos  = k[0];
        if (idx[5:4] != 2'b11) begin
            unique case (idx[2:0])
                3'd0: u.kind = U_LDU;
                3'd1: u = set_mul(u, R_U, R_U, P_RND, R_W, 1'b1);
                3'd2: begin
                    u       = set_mul(u, R_U, R_W, P_KSUB, R_R, 1'b1);
                    u.a_c11 = 1'b1;
                    u.coef  = CF_C9;
                end
                3'd3: begin
                    u      = set_mul(u, R_R, R_W, P_KSUB, R_R, 1'b1);
                    u.coef = CF_C7;
                end
                3'd4: begin
                    u      = set_mul(u, R_R, R_W, P_KSUB, R_R, 1'b1);
                    u.coef = CF_C5;
                end
                3'd5: begin
                    u      = set_mul(u, R_R, R_W, P_KSUB, R_R, 1'b1);
                    u.coef = CF_C3;
                end
                3'd6: begin
                    u      = set_mul(u, R_R, R_W, P_KSUB, R_R, 1'b1);
                    u.coef = CF_C1;
                end
                default: u = set_mul(u, R_R, R_U, P_SIN, tr, 1'b1);
            endcase
        end else begin
            unique case (idx[3:0])
                4'd0:  u = set_comp(set_mul(u, R_SY, R_CP, P_NEGSAT, R_FX, 1'b1), CI_FX);
                4'd1:  begin
                    u       = set_comp(set_mul(u, R_SP, R_U, P_NEGSAT, R_FY, 1'b1), CI_FY);
                    u.b_one = 1'b1;
                end
                4'd2:  u = set_comp(set_mul(u, R_CY, R_CP, P_SAT, R_FZ, 1'b1), CI_FZ);
                4'd3:  u = set_mul(u, R_SY, R_SP, P_RND, R_T, 1'b1);
                4'd4:  u = set_mul(u, R_T, R_SR, P_RND, R_T, 1'b1);
                4'd5:  u = set_comp(set_mul(u, R_CY, R_CR, P_SUBT, R_RX, 1'b1), CI_RX);
                4'd6:  u = set_comp(set_mul(u, R_CP, R_SR, P_SAT, R_RY, 1'b1), CI_RY);
                4'd7:  u = set_mul(u, R_CY, R_SP, P_RND, R_T, 1'b1);
                4'd8:  u = set_mul(u, R_T, R_SR, P_RND, R_T, 1'b1);
                4'd9:  u = set_comp(set_mul(u, R_SY, R_CR, P_ADDT, R_RZ, 1'b1), CI_RZ);
                4'd10: u = set_mul(u, R_FY, R_RZ, P_HOLD, R_U, 1'b0);
                4'd11: u = set_comp(set_mul(u, R_FZ, R_RY, P_XSUB, R_U, 1'b0), CI_DX);
                4'd12: u = set_mul(u, R_FZ, R_RX, P_HOLD, R_U, 1'b0);
                4'd13: u = set_comp(set_mul(u, R_FX, R_RZ, P_XSUB, R_U, 1'b0), CI_DY);
                4'd14: u = set_mul(u, R_FX, R_RY, P_HOLD, R_U, 1'b0);
                default: u = set_comp(set_mul(u, R_FY, R_RX, P_XSUB, R_U, 1'b0), CI_DZ);
            endcase
        end
        return u;
    endfunction

endpackage

// File: rtl/eaxes_ctrl.sv
// ----------------------------------------------------------------------------
// eaxes_ctrl
// Sequencer: takes an input beat, steps the datapath through the micro-op
// list and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module eaxes_ctrl
    import eaxes_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_UPD, S_STEP, S_MUL, S_POST, S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_uop       cur;

    assign cur     = uop_at(r_idx);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    // decode commands and next state
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_valid        = r_valid;
        o_cmd          = '0;
        o_cmd.uop      = cur;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_idx     = '0;
                n_state   = S_STEP;
            end
            S_STEP: begin
                if (cur.kind == U_LDU) begin
                    o_cmd.ldu = 1'b1;
                    n_idx     = r_idx + 6'd1;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_POST;
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                if (r_idx == UOP_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 6'd1;
                    n_state = S_STEP;
                end
            end
            default: begin
                if (!r_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    // hold state, index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

`ifndef SYNTH
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_valid || i_ready))
        else $error("result loaded over a pending beat");
    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_UPD))
        else $error("accepted beat not followed by update");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST && r_idx == UOP_LAST) |=> (r_state == S_DONE))
        else $error("sequence did not finish after last micro-op");
`endif

endmodule

// File: rtl/eaxes_dp.sv
// ----------------------------------------------------------------------------
// eaxes_dp
// Datapath: angle registers, a small Q30 register file, one 32x32 multiplier
// with a post stage for rounding, saturation and accumulation, and the
// output registers.
// ----------------------------------------------------------------------------
module eaxes_dp
    import eaxes_pkg::*;
#(
    parameter int TURN_BITS = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [2:0]         i_opcode,
    input  logic signed [16:0] i_angle,
    output logic signed [15:0] o_fwd_x,
    output logic signed [15:0] o_fwd_y,
    output logic signed [15:0] o_fwd_z,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic signed [15:0] o_right_z,
    output logic signed [15:0] o_down_x,
    output logic signed [15:0] o_down_y,
    output logic signed [15:0] o_down_z,
    output logic signed [16:0] o_pitch_now,
    output logic signed [16:0] o_yaw_now,
    output logic signed [16:0] o_roll_now
);

    localparam int AW = ((TURN_BITS > 16) ? TURN_BITS : 16) + 2;
    localparam int US = 32 - TURN_BITS;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic [TURN_BITS-1:0] QUARTER = TURN_BITS'(1) << (TURN_BITS - 2);
    localparam logic [31:0] HALF = (32'd1 << SH) >> 1;
    localparam logic signed [32:0] LIM = 33'(1) << FRAC_BITS;

    // truncated remainder by one turn, sign kept
    function automatic logic signed [AW-1:0] wrap_turn(input logic signed [AW-1:0] v);
        logic [AW-1:0] mag;
        logic [AW-1:0] m;
        mag = v[AW-1] ? AW'(-v) : AW'(v);
        m   = AW'(mag[TURN_BITS-1:0]);
        return v[AW-1] ? -$signed(m) : $signed(m);
    endfunction

    // Q30 to output fixed point, rounded and saturated
    function automatic logic [15:0] to_comp(input logic signed [31:0] v);
        logic [31:0]        mag;
        logic [31:0]        q;
        logic signed [32:0] s;
        mag = v[31] ? 32'(-v) : 32'(v);
        q   = (mag + HALF) >> SH;
        s   = v[31] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (s > LIM) begin
            s = LIM;
        end else if (s < -LIM) begin
            s = -LIM;
        end
        return s[15:0];
    endfunction

    logic [2:0]                r_in_op;
    logic signed [16:0]        r_in_angle;
    logic signed [AW-1:0]      r_pitch, r_yaw, r_roll;
    logic signed [31:0]        r_mem [16];
    logic signed [31:0]        r_op_a, r_op_b;
    logic signed [63:0]        r_prod, r_acc;
    logic signed [31:0]        r_t;
    logic                      r_neg;
    logic [15:0]               r_comp [NCOMP];

    logic signed [AW-1:0]      ang_ext, ang_cur;
    logic [TURN_BITS-1:0]      ph;
    logic [1:0]                quad;
    logic [TURN_BITS-2:0]      uq;
    logic [31:0]               u_val;
    logic signed [63:0]        p_rnd, x_rnd, c_sin, val;
    logic signed [31:0]        val_q30;
    t_uop                      uop;

    assign uop     = i_cmd.uop;
    assign ang_ext = {{(AW-17){r_in_angle[16]}}, r_in_angle};

    // phase to quadrant and quarter-turn fraction
    always_comb begin
        priority case (uop.ang_sel)
            ANG_PITCH: ang_cur = r_pitch;
            ANG_YAW:   ang_cur = r_yaw;
            default:   ang_cur = r_roll;
        endcase
        ph    = ang_cur[TURN_BITS-1:0] + (uop.ang_cos ? QUARTER : '0);
        quad  = ph[TURN_BITS-1:TURN_BITS-2];
        uq    = quad[0] ? (QUARTER[TURN_BITS-2:0] - {1'b0, ph[TURN_BITS-3:0]})
                        : {1'b0, ph[TURN_BITS-3:0]};
        u_val = 32'(uq) << US;
    end

    // post stage on the registered product
    always_comb begin
        p_rnd = rnd30(r_prod);
        x_rnd = rnd30(r_acc - r_prod);
        if (p_rnd < 0) begin
            c_sin = '0;
        end else if (p_rnd > Q30_ONE64) begin
            c_sin = Q30_ONE64;
        end else begin
            c_sin = p_rnd;
        end
        unique case (uop.post)
            P_RND:    val = p_rnd;
            P_KSUB:   val = 64'(coef_value(uop.coef)) - p_rnd;
            P_SIN:    val = r_neg ? -c_sin : c_sin;
            P_SAT:    val = 64'(sat_q30(p_rnd));
            P_NEGSAT: val = 64'(sat_q30(-p_rnd));
            P_SUBT:   val = 64'(sat_q30(p_rnd - 64'(r_t)));
            P_ADDT:   val = 64'(sat_q30(p_rnd + 64'(r_t)));
            P_XSUB:   val = 64'(sat_q30(x_rnd));
            default:  val = p_rnd;
        endcase
        val_q30 = val[31:0];
    end

    // update angles from the captured payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0;
            r_yaw   <= '0;
            r_roll  <= '0;
        end else if (i_cmd.upd) begin
            priority case (r_in_op)
                OPC_SET_PITCH: r_pitch <= wrap_turn(ang_ext);
                OPC_SET_YAW:   r_yaw   <= wrap_turn(ang_ext);
                OPC_SET_ROLL:  r_roll  <= wrap_turn(ang_ext);
                OPC_OFS_PITCH: r_pitch <= wrap_turn(r_pitch + ang_ext);
                OPC_OFS_YAW:   r_yaw   <= wrap_turn(r_yaw + ang_ext);
                OPC_OFS_ROLL:  r_roll  <= wrap_turn(r_roll + ang_ext);
                default: ;
            endcase
        end
    end

    // payload, register file, multiplier and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_op    <= i_opcode;
            r_in_angle <= i_angle;
        end
        if (i_cmd.ldu) begin
            r_mem[R_U] <= $signed(u_val);
            r_neg      <= quad[1];
        end else if (i_cmd.post && uop.mem_we) begin
            r_mem[uop.dst] <= val_q30;
        end
        if (i_cmd.post && uop.mem_we && uop.dst == R_T) begin
            r_t <= val_q30;
        end
        if (i_cmd.rd) begin
            r_op_a <= uop.a_c11 ? C11 : r_mem[uop.a];
            r_op_b <= uop.b_one ? Q30_ONE : r_mem[uop.b];
        end
        if (i_cmd.mul) begin
            r_prod <= r_op_a * r_op_b;
        end
        if (i_cmd.post && uop.post == P_HOLD) begin
            r_acc <= r_prod;
        end
        if (i_cmd.post && uop.comp_we) begin
            r_comp[uop.comp_idx] <= to_comp(val_q30);
        end
        if (i_cmd.out_load) begin
            o_fwd_x     <= r_comp[CI_FX];
            o_fwd_y     <= r_comp[CI_FY];
            o_fwd_z     <= r_comp[CI_FZ];
            o_right_x   <= r_comp[CI_RX];
            o_right_y   <= r_comp[CI_RY];
            o_right_z   <= r_comp[CI_RZ];
            o_down_x    <= r_comp[CI_DX];
            o_down_y    <= r_comp[CI_DY];
            o_down_z    <= r_comp[CI_DZ];
            o_pitch_now <= r_pitch[16:0];
            o_yaw_now   <= r_yaw[16:0];
            o_roll_now  <= r_roll[16:0];
        end
    end

endmodule

// File: rtl/euler_angles_to_axes_core.sv
// ----------------------------------------------------------------------------
// euler_angles_to_axes_core
// Keeps pitch, yaw and roll as binary angles, applies at most one set or offset per
// input beat and returns the forward, right and down axes with the angles.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | i_valid / o_ready  | i_opcode, i_angle
//  out     | output    | o_valid / i_ready  | nine axis components, 3 angles
//
//  A beat runs from acceptance to o_valid through an update step, six sine
//  evaluations, sixteen axis micro-ops and a load step, all on the single
//  shared 32x32 multiplier.
//  Synchronous active-low reset clears the angles to zero and the sequencer.
//  A new beat is taken while a result waits; the result load stalls until
//  the output register is free.
// ----------------------------------------------------------------------------
module euler_angles_to_axes_core
    import eaxes_pkg::*;
#(
    parameter int TURN_BITS = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_opcode,
    input  logic signed [16:0] i_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_fwd_x,
    output logic signed [15:0] o_fwd_y,
    output logic signed [15:0] o_fwd_z,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic signed [15:0] o_right_z,
    output logic signed [15:0] o_down_x,
    output logic signed [15:0] o_down_y,
    output logic signed [15:0] o_down_z,
    output logic signed [16:0] o_pitch_now,
    output logic signed [16:0] o_yaw_now,
    output logic signed [16:0] o_roll_now
);

    t_dp_cmd cmd;

    // sequencer
    eaxes_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // arithmetic and storage
    eaxes_dp #(
        .TURN_BITS (TURN_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_opcode    (i_opcode),
        .i_angle     (i_angle),
        .o_fwd_x     (o_fwd_x),
        .o_fwd_y     (o_fwd_y),
        .o_fwd_z     (o_fwd_z),
        .o_right_x   (o_right_x),
        .o_right_y   (o_right_y),
        .o_right_z   (o_right_z),
        .o_down_x    (o_down_x),
        .o_down_y    (o_down_y),
        .o_down_z    (o_down_z),
        .o_pitch_now (o_pitch_now),
        .o_yaw_now   (o_yaw_now),
        .o_roll_now  (o_roll_now)
    );

endmodule

// File: tb/tb_euler_angles_to_axes_core.sv
// ----------------------------------------------------------------------------
// tb_euler_angles_to_axes_core
// Drives set, offset and no-op beats into the Euler angle block, predicts the axes
// and angles with a local fixed-point model and checks every output beat.
// ----------------------------------------------------------------------------
module tb_euler_angles_to_axes_core
    import eaxes_pkg::*;
;

    localparam longint ONE30   = 64'sd1073741824;
    localparam longint TURN    = 64'sd65536;
    localparam longint QUARTER = 64'sd16384;
    localparam int     WD_MAX  = 4000;

    // opcodes with no angle update
    localparam logic [2:0] OPC_SPARE_A = 3'd6;
    localparam logic [2:0] OPC_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [15:0] fx, fy, fz, rx, ry, rz, dx, dy, dz;
        logic signed [16:0] pitch, yaw, roll;
    } t_axes;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_opcode = '0;
    logic signed [16:0] i_angle = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_fwd_x, o_fwd_y, o_fwd_z;
    logic signed [15:0] o_right_x, o_right_y, o_right_z;
    logic signed [15:0] o_down_x, o_down_y, o_down_z;
    logic signed [16:0] o_pitch_now, o_yaw_now, o_roll_now;

    longint pitch_st, yaw_st, roll_st;
    t_axes  axes_q[$];
    int     n_mismatch = 0;
    int     idle_cycles = 0;
    int     rdy_wait = 0;

    euler_angles_to_axes_core i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // -------- prediction --------
    function automatic longint rnd_sh(longint p, int sh);
        longint half;
        half = 64'sd1 <<< (sh - 1);
        if (p >= 0) return (p + half) >>> sh;
        return -((-p + half) >>> sh);
    endfunction

    function automatic longint qm(longint a, longint b);
        return rnd_sh(a * b, 30);
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint quarter_sine(longint u);
        longint w, r;
        w = qm(u, u);
        r = 3864;
        r = 172272 - qm(r, w);
        r = 5026995 - qm(r, w);
        r = 85569306 - qm(r, w);
        r = 693598668 - qm(r, w);
        r = 1686629713 - qm(r, w);
        r = qm(r, u);
        if (r < 0) r = 0;
        if (r > ONE30) r = ONE30;
        return r;
    endfunction

    function automatic longint angle_sine(longint a);
        longint p, rem, s;
        int quad;
        p    = a & (TURN - 1);
        quad = int'((p >> 14) & 3);
        rem  = p & (QUARTER - 1);
        if (quad[0]) s = quarter_sine((QUARTER - rem) <<< 16);
        else s = quarter_sine(rem <<< 16);
        return quad[1] ? -s : s;
    endfunction

    function automatic logic signed [15:0] to_q14(longint q30);
        return 16'(clip(rnd_sh(q30, 16), 16384));
    endfunction

    function automatic t_axes axes_after(logic [2:0] opc, logic signed [16:0] ang);
        longint a, sp, cp, sy, cy, sr, cr, fx, fy, fz, rx, ry, rz, dx, dy, dz;
        t_axes  e;
        a = longint'(ang);
        case (opc)
            OPC_SET_PITCH: pitch_st = a % TURN;
            OPC_SET_YAW:   yaw_st = a % TURN;
            OPC_SET_ROLL:  roll_st = a % TURN;
            OPC_OFS_PITCH: pitch_st = (pitch_st + a) % TURN;
            OPC_OFS_YAW:   yaw_st = (yaw_st + a) % TURN;
            OPC_OFS_ROLL:  roll_st = (roll_st + a) % TURN;
            default: ;
        endcase
        sp = angle_sine(pitch_st); cp = angle_sine(pitch_st + QUARTER);
        sy = angle_sine(yaw_st);   cy = angle_sine(yaw_st + QUARTER);
        sr = angle_sine(roll_st);  cr = angle_sine(roll_st + QUARTER);
        fx = clip(-qm(sy, cp), ONE30);
        fy = clip(-sp, ONE30);
        fz = clip(qm(cy, cp), ONE30);
        rx = clip(-qm(qm(sy, sp), sr) + qm(cy, cr), ONE30);
        ry = clip(qm(cp, sr), ONE30);
        rz = clip(qm(qm(cy, sp), sr) + qm(sy, cr), ONE30);
        dx = clip(rnd_sh(fy * rz - fz * ry, 30), ONE30);
        dy = clip(rnd_sh(fz * rx - fx * rz, 30), ONE30);
        dz = clip(rnd_sh(fx * ry - fy * rx, 30), ONE30);
        e.fx = to_q14(fx); e.fy = to_q14(fy); e.fz = to_q14(fz);
        e.rx = to_q14(rx); e.ry = to_q14(ry); e.rz = to_q14(rz);
        e.dx = to_q14(dx); e.dy = to_q14(dy); e.dz = to_q14(dz);
        e.pitch = 17'(pitch_st); e.yaw = 17'(yaw_st); e.roll = 17'(roll_st);
        return e;
    endfunction

    // -------- stimulus --------
    task automatic send_beat(logic [2:0] opc, logic signed [16:0] ang);
        int gap;
        gap = $urandom_range(0, 9);
        // drop valid only while idling between beats
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= opc;
        i_angle  <= ang;
        axes_q.push_back(axes_after(opc, ang));
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic signed [16:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return 17'sd65535;
            1: return -17'sd65535;
            2: return -17'sd65536;
            3: return 17'($urandom_range(0, 255) - 128);
            default: return 17'($urandom());
        endcase
    endfunction

    task automatic test_extremes();
        logic [2:0] set_ops [3];
        set_ops = '{OPC_SET_PITCH, OPC_SET_YAW, OPC_SET_ROLL};
        for (int k = 0; k < 3; k++) begin
            send_beat(set_ops[k], 17'sd65535);
            send_beat(set_ops[k], -17'sd65535);
            send_beat(set_ops[k], -17'sd65536);
            send_beat(set_ops[k], 17'sd16384);
        end
    endtask

    task automatic test_offsets();
        send_beat(OPC_SET_PITCH, 17'sd60000);
        send_beat(OPC_OFS_PITCH, 17'sd60000);
        send_beat(OPC_SET_YAW, -17'sd60000);
        send_beat(OPC_OFS_YAW, -17'sd65535);
        send_beat(OPC_SET_ROLL, 17'sd32768);
        send_beat(OPC_OFS_ROLL, 17'sd65535);
        send_beat(OPC_OFS_ROLL, 17'sd0);
    endtask

    task automatic test_unused_opcodes();
        send_beat(OPC_SPARE_A, 17'sd12345);
        send_beat(OPC_SPARE_B, -17'sd1);
    endtask

    task automatic test_random();
        for (int n = 0; n < 750; n++)
            send_beat(3'($urandom_range(0, 7)), rand_angle());
    endtask

    // -------- output side --------
    // after each output beat, draw a random wait; ready stays low until it runs out
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            rdy_wait <= 1;
        end else if (o_valid && i_ready) begin
            w = $urandom_range(0, 9);
            rdy_wait <= w;
            i_ready  <= (w == 0);
        end else if (rdy_wait != 0) begin
            rdy_wait <= rdy_wait - 1;
            if (rdy_wait == 1) i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_axes got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_fwd_x, o_fwd_y, o_fwd_z, o_right_x, o_right_y, o_right_z,
                   o_down_x, o_down_y, o_down_z, o_pitch_now, o_yaw_now, o_roll_now};
            if (axes_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected output beat %h", got);
            end else begin
                want = axes_q.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    // -------- watchdog --------
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        pitch_st = 0; yaw_st = 0; roll_st = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_offsets();
        test_unused_opcodes();
        test_random();
        i_valid <= 1'b0;
        while (axes_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/eaxes_pkg.sv
rtl/eaxes_ctrl.sv
rtl/eaxes_dp.sv
rtl/euler_angles_to_axes_core.sv
tb/tb_euler_angles_to_axes_core.sv
